// File: rtl/rlt_pkg.sv
// ----------------------------------------------------------------------------
// rlt_pkg
// Shared types and constants for the run-length table unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rlt_pkg;

  localparam int VALUE_W  = 32;
  localparam int OFFSET_W = 24;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic                       lookup;
    logic signed [VALUE_W-1:0]  value;
    logic        [OFFSET_W-1:0] offset;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/rlt_ram.sv
// ----------------------------------------------------------------------------
// rlt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rlt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/rlt_front.sv
// ----------------------------------------------------------------------------
// rlt_front
// Accepts command transfers, decodes the operation, and holds them in a
// two-entry queue for the execution side.
// ----------------------------------------------------------------------------
`default_nettype none

module rlt_front
  import rlt_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       func,
  input  wire logic signed [VALUE_W-1:0]  value,
  input  wire logic        [OFFSET_W-1:0] offset,
  output logic                            cmd_valid,
  output cmd_t                            cmd,
  input  wire logic                       cmd_pop
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  cmd_t       item;

  assign busy      = (count == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slots[rd_ptr];

  always_comb begin
    item.lookup = (func == OP_LOOKUP);
    item.value  = value;
    item.offset = offset;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, cmd_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/rlt_back.sv
// ----------------------------------------------------------------------------
// rlt_back
// Executes appends against the cached last run and walks the run table
// for lookups, one memory read issued per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rlt_back
  import rlt_pkg::*;
#(
  parameter int MAX_RUNS    = 256,
  parameter int LENGTH_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cmd_valid,
  input  wire cmd_t                      cmd,
  output logic                           cmd_pop,
  output logic                           done,
  output logic signed [VALUE_W-1:0]      read_value,
  output logic                           hit,
  output logic                           table_full
);

  localparam int IDX_W = $clog2(MAX_RUNS);
  localparam int RUN_W = $clog2(MAX_RUNS + 1);
  localparam int SUM_W = LENGTH_BITS + RUN_W;
  localparam int CMP_W = (SUM_W > OFFSET_W) ? SUM_W : OFFSET_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic                     state;
  logic [RUN_W-1:0]         used_runs;
  logic [VALUE_W-1:0]       last_value;
  logic [LENGTH_BITS-1:0]   last_length;
  logic [RUN_W-1:0]         idx;
  logic                     pend;
  logic [SUM_W-1:0]         run_start;
  logic [OFFSET_W-1:0]      look_off;

  logic                     app_go;
  logic                     look_go;
  logic                     ext_ok;
  logic                     room;
  logic [IDX_W-1:0]         last_idx;
  logic [IDX_W-1:0]         used_idx;
  logic                     len_we;
  logic                     val_we;
  logic [IDX_W-1:0]         waddr;
  logic [LENGTH_BITS-1:0]   len_wdata;
  logic [LENGTH_BITS-1:0]   len_rdata;
  logic [VALUE_W-1:0]       val_rdata;
  logic                     issue;
  logic [SUM_W-1:0]         run_end;
  logic                     found;
  logic                     walk_end;
  logic [RUN_W-1:0]         used_m1;

  assign cmd_pop  = cmd_valid && (state == ST_IDLE);
  assign app_go   = cmd_pop && !cmd.lookup;
  assign look_go  = cmd_pop && cmd.lookup;
  assign used_m1  = used_runs - RUN_W'(1);
  assign last_idx = used_m1[IDX_W-1:0];
  assign used_idx = used_runs[IDX_W-1:0];
  assign room     = (used_runs < RUN_W'(MAX_RUNS));
  assign ext_ok   = (used_runs != '0) && (last_value == cmd.value)
                    && (last_length != {LENGTH_BITS{1'b1}});
  assign len_we   = app_go && (ext_ok || room);
  assign val_we   = app_go && !ext_ok && room;
  assign waddr    = ext_ok ? last_idx : used_idx;
  assign len_wdata = ext_ok ? (last_length + LENGTH_BITS'(1)) : LENGTH_BITS'(1);

  assign issue    = (state == ST_WALK) && (idx < used_runs);
  assign run_end  = run_start + SUM_W'(len_rdata);
  assign found    = pend && (CMP_W'(look_off) < CMP_W'(run_end));
  assign walk_end = (state == ST_WALK) && (found || (!pend && !issue));

  rlt_ram #(.WIDTH(LENGTH_BITS), .DEPTH(MAX_RUNS)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (waddr),
    .wdata (len_wdata),
    .raddr (idx[IDX_W-1:0]),
    .rdata (len_rdata)
  );

  rlt_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_RUNS)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (waddr),
    .wdata (cmd.value),
    .raddr (idx[IDX_W-1:0]),
    .rdata (val_rdata)
  );

  always_ff @(posedge clk) begin
    if (app_go) begin
      if (ext_ok) begin
        last_length <= len_wdata;
      end else if (room) begin
        last_value  <= cmd.value;
        last_length <= LENGTH_BITS'(1);
      end
      read_value <= '0;
      hit        <= 1'b0;
      table_full <= !ext_ok && !room;
    end
    if (look_go) begin
      look_off  <= cmd.offset;
      idx       <= '0;
      run_start <= '0;
    end
    if (state == ST_WALK) begin
      if (issue) begin
        idx <= idx + RUN_W'(1);
      end
      if (pend) begin
        run_start <= run_end;
      end
      table_full <= 1'b0;
      if (found) begin
        read_value <= val_rdata;
        hit        <= 1'b1;
      end else begin
        read_value <= '0;
        hit        <= 1'b0;
      end
    end
    if (rst) begin
      state     <= ST_IDLE;
      used_runs <= '0;
      pend      <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= app_go || walk_end;
      case (state)
        ST_IDLE: begin
          pend <= 1'b0;
          if (app_go) begin
            if (!ext_ok && room) begin
              used_runs <= used_runs + RUN_W'(1);
            end
          end else if (look_go) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (walk_end) begin
            pend  <= 1'b0;
            state <= ST_IDLE;
          end else begin
            pend <= issue;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/run_length_table_unit.sv
// ----------------------------------------------------------------------------
// run_length_table_unit
// Run-length-compressed array: appends extend or open runs, lookups walk
// the runs to find the element at a zero-based offset.
// ----------------------------------------------------------------------------
// From the start transfer, a command passes the front queue and then the back
// end; a lookup walks the stored runs up to the run that holds the offset, or
// all of them on a miss, with one length/value memory read per cycle.
// Appends run one per cycle while no lookup walk is in progress; a two-entry
// command queue holds start transfers.
// Reset empties the table and the queue; results have no back pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module run_length_table_unit
  import rlt_pkg::*;
#(
  parameter int MAX_RUNS    = 256,
  parameter int LENGTH_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       func,
  input  wire logic signed [VALUE_W-1:0]  value,
  input  wire logic        [OFFSET_W-1:0] offset,
  output logic                            done,
  output logic signed [VALUE_W-1:0]       read_value,
  output logic                            hit,
  output logic                            table_full
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  rlt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .func      (func),
    .value     (value),
    .offset    (offset),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  rlt_back #(
    .MAX_RUNS    (MAX_RUNS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .done       (done),
    .read_value (read_value),
    .hit        (hit),
    .table_full (table_full)
  );

endmodule

`default_nettype wire

// File: bench/run_length_table_unit_tb.sv
// ----------------------------------------------------------------------------
// run_length_table_unit_tb
// Self-checking bench for the run-length table unit. It sends append and
// lookup commands through the start/busy transfer and predicts each result
// with its own copy of the run table. Results are checked in order, field
// by field, as they are strobed by done. The sequence covers an empty table,
// value extremes, a full table and three random phases with different
// sender idle rates.
// ----------------------------------------------------------------------------
`default_nettype none

module run_length_table_unit_tb;
  import rlt_pkg::*;

  localparam int MAX_RUNS    = 256;
  localparam int LENGTH_BITS = 16;
  localparam int MAX_LEN     = (1 << LENGTH_BITS) - 1;
  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int DRAIN_WAIT  = MAX_RUNS + 16;

  typedef struct {
    logic signed [VALUE_W-1:0] read_value;
    logic                      hit;
    logic                      table_full;
  } table_result_t;

  logic                       clk        = 1'b0;
  logic                       rst        = 1'b1;
  logic                       start      = 1'b0;
  logic                       func       = OP_APPEND;
  logic signed [VALUE_W-1:0]  value      = '0;
  logic        [OFFSET_W-1:0] offset     = '0;
  logic                       busy;
  logic                       done;
  logic signed [VALUE_W-1:0]  read_value;
  logic                       hit;
  logic                       table_full;

  // Predicted table state
  logic signed [VALUE_W-1:0]  run_vals [MAX_RUNS];
  logic [LENGTH_BITS-1:0]     run_lens [MAX_RUNS];
  int                         runs_used  = 0;
  longint                     elem_total = 0;

  table_result_t              pending_results[$];
  int                         fail_count  = 0;
  int                         cycle_count = 0;
  int                         idle_pct    = 0;

  run_length_table_unit #(
    .MAX_RUNS    (MAX_RUNS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .value      (value),
    .offset     (offset),
    .done       (done),
    .read_value (read_value),
    .hit        (hit),
    .table_full (table_full)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run_length_table_unit_tb: FAIL");
      $finish;
    end
  end

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  // Updates the predicted table and returns the result the item must give.
  function automatic table_result_t run_table_result(input logic f,
                                                     input logic signed [VALUE_W-1:0] v,
                                                     input logic [OFFSET_W-1:0] off);
    table_result_t r;
    longint        run_end;
    r = '{read_value: '0, hit: 1'b0, table_full: 1'b0};
    if (f == OP_APPEND) begin
      if (runs_used > 0 && run_vals[runs_used-1] == v && run_lens[runs_used-1] < MAX_LEN) begin
        run_lens[runs_used-1] = run_lens[runs_used-1] + 1'b1;
        elem_total++;
      end else if (runs_used < MAX_RUNS) begin
        run_vals[runs_used] = v;
        run_lens[runs_used] = LENGTH_BITS'(1);
        runs_used++;
        elem_total++;
      end else begin
        r.table_full = 1'b1;
      end
    end else begin
      run_end = 0;
      for (int i = 0; i < runs_used; i++) begin
        run_end += run_lens[i];
        if (off < run_end) begin
          r.read_value = run_vals[i];
          r.hit        = 1'b1;
          break;
        end
      end
    end
    return r;
  endfunction

  // Called at a rising edge; returns at the edge of the transfer.
  task automatic send_item(input logic f, input logic signed [VALUE_W-1:0] v,
                           input logic [OFFSET_W-1:0] off);
    int gap;
    bit taken;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      gap = ($urandom_range(7) == 0) ? $urandom_range(300, 20) : $urandom_range(6, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    func   <= f;
    value  <= v;
    offset <= off;
    do begin
      @(negedge clk);
      taken = (busy === 1'b0);
      @(posedge clk);
    end while (!taken);
    pending_results.push_back(run_table_result(f, v, off));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    table_result_t want;
    if (!rst && done !== 1'b0) begin
      if (pending_results.size() == 0) begin
        log_failure($sformatf("unexpected result: value %0d hit %b full %b",
                              read_value, hit, table_full));
      end else begin
        want = pending_results.pop_front();
        if (read_value !== want.read_value || hit !== want.hit ||
            table_full !== want.table_full) begin
          log_failure($sformatf(
            "mismatch: expected value %0d hit %b full %b, got value %0d hit %b full %b",
            want.read_value, want.hit, want.table_full, read_value, hit, table_full));
        end
      end
    end
  end

  task automatic test_empty_table();
    idle_pct = 0;
    send_item(OP_LOOKUP, '0, '0);
    send_item(OP_LOOKUP, '1, '1);
  endtask

  task automatic test_append_extremes();
    idle_pct = 0;
    repeat (3) send_item(OP_APPEND, 32'sh8000_0000, '0);
    send_item(OP_APPEND, 32'sh7FFF_FFFF, '1);
    repeat (2) send_item(OP_APPEND, '0, '0);
    send_item(OP_APPEND, -32'sd1, '0);
    for (int i = 0; i <= 7; i++) begin
      send_item(OP_LOOKUP, '0, OFFSET_W'(i));
    end
    send_item(OP_LOOKUP, '0, '1);
  endtask

  task automatic test_random_mix(input int count, input int pct);
    logic signed [VALUE_W-1:0] value_pool [4];
    logic signed [VALUE_W-1:0] v;
    logic [OFFSET_W-1:0]       off;
    longint                    run_start;
    int                        sel;
    int                        idx;
    idle_pct = pct;
    foreach (value_pool[i]) value_pool[i] = $urandom;
    repeat (count) begin
      sel = $urandom_range(99);
      if ($urandom_range(99) < 45) begin
        if (elem_total == 0 || sel < 15) begin
          off = OFFSET_W'($urandom_range(24'hFF_FFFF));
        end else if (sel < 30) begin
          off = OFFSET_W'(elem_total + $urandom_range(3));
        end else if (sel < 45) begin
          idx = $urandom_range(runs_used - 1);
          run_start = 0;
          for (int j = 0; j < idx; j++) run_start += run_lens[j];
          if (run_start > 0 && $urandom_range(1)) run_start--;
          off = OFFSET_W'(run_start);
        end else begin
          off = OFFSET_W'($urandom_range(int'(elem_total - 1)));
        end
        send_item(OP_LOOKUP, $urandom, off);
      end else begin
        if (sel < 50 && runs_used > 0) v = run_vals[runs_used-1];
        else if (sel < 75) v = value_pool[$urandom_range(3)];
        else v = $urandom;
        send_item(OP_APPEND, v, OFFSET_W'($urandom_range(24'hFF_FFFF)));
      end
    end
  endtask

  task automatic test_table_full();
    logic signed [VALUE_W-1:0] v;
    idle_pct = 10;
    while (runs_used < MAX_RUNS) begin
      v = $urandom;
      if (runs_used > 0 && v == run_vals[runs_used-1]) v = ~v;
      send_item(OP_APPEND, v, '0);
    end
    repeat (3) begin
      v = ~run_vals[MAX_RUNS-1];
      send_item(OP_APPEND, v, '0);
    end
    send_item(OP_LOOKUP, '0, OFFSET_W'(elem_total - 1));
    send_item(OP_LOOKUP, '0, OFFSET_W'(elem_total));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_append_extremes();
    test_random_mix(480, 10);
    wait_drained();
    test_random_mix(480, 55);
    test_random_mix(480, 0);
    wait_drained();
    test_table_full();
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("run_length_table_unit_tb: PASS");
    end else begin
      $display("run_length_table_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
